FILE: sv/sgcc_pkg.sv
// shared widths, codes and control types of the segment grid cell cover
package sgcc_pkg;

  localparam int LAT_W     = 30;
  localparam int LON_W     = 31;
  localparam int CS_W      = 31;
  localparam int CNT_W     = 11;
  localparam int IDX_W     = 10;
  localparam int NUM_W     = 20;
  localparam int DIV_W     = 31;
  localparam int MUL_W     = 35;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LON = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = 3'd4;

  localparam logic [CS_W-1:0]  CELL_SIZE_RST = 31'd4194304;
  localparam logic [CNT_W-1:0] CELLS_RST     = 11'd1;

  typedef enum logic [2:0] {
    SRC_START,
    SRC_END,
    SRC_SCAN,
    SRC_OOR,
    SRC_SPAN
  } src_e;

  typedef enum logic [1:0] {
    DS_SY,
    DS_SX,
    DS_EY,
    DS_EX
  } div_sel_e;

  typedef enum logic [1:0] {
    MS_DY,
    MS_DX,
    MS_EY,
    MS_EX
  } mul_sel_e;

  typedef struct packed {
    logic     ld_in;
    logic     div_go;
    div_sel_e div_sel;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     push;
    src_e     src;
    logic     scan_init;
    logic     scan_step;
    logic     flush;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic oor;
    logic span;
    logic same_cell;
    logic scan_last;
    logic hit;
  } sts_t;

endpackage

FILE: sv/segment_grid_cell_cover.sv
// top level: configuration registers, controller and datapath of the cell cover
//
//   port group       direction  handshake
//   segment input    in         start_i accepted when busy_o is low
//   cell result      out        out_valid_o strobe, one cycle per transaction
//   configuration    in         cfg_we_i write, index cfg_idx_i, data cfg_data_i
//
// a segment runs four passes of the one-bit-per-cycle divider and four of the
// one-bit-per-cycle multiplier, then scans its bounding box (at most 64 cells)
// unless both ends share a cell; an error segment ends after the divider passes.
// reset clears control state and loads the register reset values.
// results leave one per cycle at most; the receiver cannot stall them.
module segment_grid_cell_cover #(
  parameter int MAX_GRID_SIDE = 1024,
  parameter int MAX_SPAN      = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [sgcc_pkg::LAT_W-1:0]         start_lat_i,
  input  logic [sgcc_pkg::LON_W-1:0]         start_lon_i,
  input  logic [sgcc_pkg::LAT_W-1:0]         end_lat_i,
  input  logic [sgcc_pkg::LON_W-1:0]         end_lon_i,
  input  logic                               cfg_we_i,
  input  logic [sgcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sgcc_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                               out_valid_o,
  output logic [sgcc_pkg::IDX_W-1:0]         col_index_o,
  output logic [sgcc_pkg::IDX_W-1:0]         row_index_o,
  output logic [sgcc_pkg::NUM_W-1:0]         cell_number_o,
  output logic                               out_of_range_o,
  output logic                               span_too_long_o,
  output logic                               last_cell_o
);

  localparam int LAT_W = sgcc_pkg::LAT_W;
  localparam int LON_W = sgcc_pkg::LON_W;
  localparam int CS_W  = sgcc_pkg::CS_W;
  localparam int CNT_W = sgcc_pkg::CNT_W;

  logic [LAT_W-1:0] origin_lat_q;
  logic [LON_W-1:0] origin_lon_q;
  logic [CS_W-1:0]  cell_size_q;
  logic [CNT_W-1:0] cells_x_q, cells_y_q, nx, ny;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_lat_q <= '0;
      origin_lon_q <= '0;
      cell_size_q  <= sgcc_pkg::CELL_SIZE_RST;
      cells_x_q    <= sgcc_pkg::CELLS_RST;
      cells_y_q    <= sgcc_pkg::CELLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgcc_pkg::REG_ORIGIN_LAT: origin_lat_q <= cfg_data_i[LAT_W-1:0];
        sgcc_pkg::REG_ORIGIN_LON: origin_lon_q <= cfg_data_i[LON_W-1:0];
        sgcc_pkg::REG_CELL_SIZE:  cell_size_q  <= cfg_data_i[CS_W-1:0];
        sgcc_pkg::REG_CELLS_X:    cells_x_q    <= cfg_data_i[CNT_W-1:0];
        sgcc_pkg::REG_CELLS_Y:    cells_y_q    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // grid side clamp
  assign nx = (32'(cells_x_q) > 32'(MAX_GRID_SIDE)) ? CNT_W'(MAX_GRID_SIDE) : cells_x_q;
  assign ny = (32'(cells_y_q) > 32'(MAX_GRID_SIDE)) ? CNT_W'(MAX_GRID_SIDE) : cells_y_q;

  sgcc_pkg::cmd_t cmd;
  sgcc_pkg::sts_t sts;

  sgcc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  sgcc_dp #(
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_lat_i     (start_lat_i),
    .start_lon_i     (start_lon_i),
    .end_lat_i       (end_lat_i),
    .end_lon_i       (end_lon_i),
    .origin_lat_i    (origin_lat_q),
    .origin_lon_i    (origin_lon_q),
    .cell_size_i     (cell_size_q),
    .nx_i            (nx),
    .ny_i            (ny),
    .out_valid_o     (out_valid_o),
    .col_index_o     (col_index_o),
    .row_index_o     (row_index_o),
    .cell_number_o   (cell_number_o),
    .out_of_range_o  (out_of_range_o),
    .span_too_long_o (span_too_long_o),
    .last_cell_o     (last_cell_o)
  );

  a_oor_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> last_cell_o && !span_too_long_o)
    else $error("out of range result not alone");

  a_span_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && span_too_long_o |-> last_cell_o && !out_of_range_o)
    else $error("span result not alone");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_cell_o |=> !out_valid_o)
    else $error("result after last cell");

endmodule

FILE: sv/sgcc_div.sv
// restoring divider, one quotient bit per cycle
module sgcc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [sgcc_pkg::DIV_W-1:0]    num_i,
  input  logic [sgcc_pkg::DIV_W-1:0]    den_i,
  output logic                          done_o,
  output logic [sgcc_pkg::DIV_W-1:0]    quo_o,
  output logic [sgcc_pkg::DIV_W-1:0]    rem_o
);

  localparam int DW = sgcc_pkg::DIV_W;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem_q, quo_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [DW:0]   shifted, diff;
  logic          ge;
  logic [DW-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, den_i};
    ge      = shifted >= {1'b0, den_i};
    rem_d   = ge ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (go_i) begin
      rem_q  <= '0;
      quo_q  <= num_i;
      cnt_q  <= CW'(DW);
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DW-2:0], ge};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/sgcc_mul.sv
// signed shift-add multiplier, one operand bit per cycle
module sgcc_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  logic signed [sgcc_pkg::MUL_W-1:0] a_i,
  input  logic signed [sgcc_pkg::MUL_W-1:0] b_i,
  output logic                              done_o,
  output logic [sgcc_pkg::PROD_W-1:0]       prod_o
);

  localparam int MW = sgcc_pkg::MUL_W;
  localparam int PW = sgcc_pkg::PROD_W;
  localparam int CW = $clog2(MW + 1);

  logic [MW:0]   hi_q;
  logic [MW-1:0] lo_q, mc_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q, run_q, done_q;
  logic [MW-1:0] ma, mb;
  logic [MW:0]   sum;
  logic [PW-1:0] mag;

  always_comb begin
    ma  = a_i[MW-1] ? MW'(-a_i) : MW'(a_i);
    mb  = b_i[MW-1] ? MW'(-b_i) : MW'(b_i);
    sum = hi_q + (lo_q[0] ? {1'b0, mc_q} : '0);
    mag = {hi_q[MW-1:0], lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q   <= '0;
      lo_q   <= '0;
      mc_q   <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (go_i) begin
      hi_q   <= '0;
      lo_q   <= mb;
      mc_q   <= ma;
      neg_q  <= a_i[MW-1] ^ b_i[MW-1];
      cnt_q  <= CW'(MW);
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      hi_q  <= {1'b0, sum[MW:1]};
      lo_q  <= {sum[0], lo_q[MW-1:1]};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -mag : mag;

endmodule

FILE: sv/sgcc_dp.sv
// datapath: endpoint cells, line coefficients, cell scan and result staging
module sgcc_dp #(
  parameter int MAX_SPAN = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sgcc_pkg::cmd_t                    cmd_i,
  output sgcc_pkg::sts_t                    sts_o,
  input  logic [sgcc_pkg::LAT_W-1:0]        start_lat_i,
  input  logic [sgcc_pkg::LON_W-1:0]        start_lon_i,
  input  logic [sgcc_pkg::LAT_W-1:0]        end_lat_i,
  input  logic [sgcc_pkg::LON_W-1:0]        end_lon_i,
  input  logic [sgcc_pkg::LAT_W-1:0]        origin_lat_i,
  input  logic [sgcc_pkg::LON_W-1:0]        origin_lon_i,
  input  logic [sgcc_pkg::CS_W-1:0]         cell_size_i,
  input  logic [sgcc_pkg::CNT_W-1:0]        nx_i,
  input  logic [sgcc_pkg::CNT_W-1:0]        ny_i,
  output logic                              out_valid_o,
  output logic [sgcc_pkg::IDX_W-1:0]        col_index_o,
  output logic [sgcc_pkg::IDX_W-1:0]        row_index_o,
  output logic [sgcc_pkg::NUM_W-1:0]        cell_number_o,
  output logic                              out_of_range_o,
  output logic                              span_too_long_o,
  output logic                              last_cell_o
);

  localparam int LAT_W  = sgcc_pkg::LAT_W;
  localparam int LON_W  = sgcc_pkg::LON_W;
  localparam int CNT_W  = sgcc_pkg::CNT_W;
  localparam int IDX_W  = sgcc_pkg::IDX_W;
  localparam int NUM_W  = sgcc_pkg::NUM_W;
  localparam int DIV_W  = sgcc_pkg::DIV_W;
  localparam int MUL_W  = sgcc_pkg::MUL_W;
  localparam int PW     = sgcc_pkg::PROD_W;
  localparam int SPAN_W = $clog2(MAX_SPAN);

  // latched segment
  logic [LAT_W-1:0] s_lat_q, e_lat_q;
  logic [LON_W-1:0] s_lon_q, e_lon_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      s_lat_q <= start_lat_i;
      s_lon_q <= start_lon_i;
      e_lat_q <= end_lat_i;
      e_lon_q <= end_lon_i;
    end
  end

  // offsets from the grid origin
  logic [LAT_W:0] dsy, dey, uy;
  logic [LON_W:0] dsx, dex, ux;

  always_comb begin
    dsy = {s_lat_q[LAT_W-1], s_lat_q} - {origin_lat_i[LAT_W-1], origin_lat_i};
    dey = {e_lat_q[LAT_W-1], e_lat_q} - {origin_lat_i[LAT_W-1], origin_lat_i};
    dsx = {s_lon_q[LON_W-1], s_lon_q} - {origin_lon_i[LON_W-1], origin_lon_i};
    dex = {e_lon_q[LON_W-1], e_lon_q} - {origin_lon_i[LON_W-1], origin_lon_i};
    uy  = {e_lat_q[LAT_W-1], e_lat_q} - {s_lat_q[LAT_W-1], s_lat_q};
    ux  = {e_lon_q[LON_W-1], e_lon_q} - {s_lon_q[LON_W-1], s_lon_q};
  end

  // endpoint cell divisions
  logic [DIV_W-1:0] div_num, quo, rem;
  logic             div_neg, div_done;
  logic [CNT_W-1:0] div_lim;

  always_comb begin
    case (cmd_i.div_sel)
      sgcc_pkg::DS_SY: begin
        div_num = DIV_W'(dsy);
        div_neg = dsy[LAT_W];
        div_lim = ny_i;
      end
      sgcc_pkg::DS_SX: begin
        div_num = dsx[DIV_W-1:0];
        div_neg = dsx[LON_W];
        div_lim = nx_i;
      end
      sgcc_pkg::DS_EY: begin
        div_num = DIV_W'(dey);
        div_neg = dey[LAT_W];
        div_lim = ny_i;
      end
      default: begin
        div_num = dex[DIV_W-1:0];
        div_neg = dex[LON_W];
        div_lim = nx_i;
      end
    endcase
  end

  sgcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.div_go),
    .num_i  (div_num),
    .den_i  (cell_size_i),
    .done_o (div_done),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  logic [CNT_W-1:0] sr_q, sc_q, er_q, ec_q;
  logic [DIV_W-1:0] rys_q, rxs_q;
  logic [3:0]       bad_q;
  logic             cell_ok;

  assign cell_ok = !div_neg && (cell_size_i != '0) && (quo < DIV_W'(div_lim));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= '0;
    end else if (div_done) begin
      bad_q[cmd_i.div_sel] <= !cell_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (cmd_i.div_sel)
        sgcc_pkg::DS_SY: begin
          sr_q  <= quo[CNT_W-1:0];
          rys_q <= rem;
        end
        sgcc_pkg::DS_SX: begin
          sc_q  <= quo[CNT_W-1:0];
          rxs_q <= rem;
        end
        sgcc_pkg::DS_EY: er_q <= quo[CNT_W-1:0];
        default:         ec_q <= quo[CNT_W-1:0];
      endcase
    end
  end

  // bounding box
  logic [CNT_W-1:0] c0, c1, r0, r1, cw, rw;
  logic             span;

  always_comb begin
    c0   = (sc_q < ec_q) ? sc_q : ec_q;
    c1   = (sc_q < ec_q) ? ec_q : sc_q;
    r0   = (sr_q < er_q) ? sr_q : er_q;
    r1   = (sr_q < er_q) ? er_q : sr_q;
    cw   = c1 - c0;
    rw   = r1 - r0;
    span = (32'(cw) >= 32'(MAX_SPAN)) || (32'(rw) >= 32'(MAX_SPAN));
  end

  // line coefficients: f(x, y) = ux * (y - py) - uy * (x - px) at cell corners
  logic [SPAN_W-1:0]        dys, dxs;
  logic [MUL_W-1:0]         ey_mag, ex_mag;
  logic signed [MUL_W-1:0]  ux_m, uy_m, cs_m, ey, ex, mul_a, mul_b;
  logic [PW-1:0]            prod;
  logic                     mul_done;

  always_comb begin
    dys    = SPAN_W'(sr_q - r0);
    dxs    = SPAN_W'(sc_q - c0);
    ey_mag = MUL_W'(dys) * MUL_W'(cell_size_i) + MUL_W'(rys_q);
    ex_mag = MUL_W'(dxs) * MUL_W'(cell_size_i) + MUL_W'(rxs_q);
    ey     = -$signed(ey_mag);
    ex     = -$signed(ex_mag);
    ux_m   = MUL_W'($signed(ux));
    uy_m   = MUL_W'($signed(uy));
    cs_m   = $signed(MUL_W'(cell_size_i));
    case (cmd_i.mul_sel)
      sgcc_pkg::MS_DY: begin
        mul_a = ux_m;
        mul_b = cs_m;
      end
      sgcc_pkg::MS_DX: begin
        mul_a = uy_m;
        mul_b = cs_m;
      end
      sgcc_pkg::MS_EY: begin
        mul_a = ux_m;
        mul_b = ey;
      end
      default: begin
        mul_a = uy_m;
        mul_b = ex;
      end
    endcase
  end

  sgcc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  logic [PW-1:0] dy_q, dx_q, dxy_q, p3_q, f0_q;

  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      case (cmd_i.mul_sel)
        sgcc_pkg::MS_DY: dy_q <= prod;
        sgcc_pkg::MS_DX: begin
          dx_q  <= -prod;
          dxy_q <= dy_q - prod;
        end
        sgcc_pkg::MS_EY: p3_q <= prod;
        default:         f0_q <= p3_q - prod;
      endcase
    end
  end

  // box scan, column by column, rows ascending
  logic [CNT_W-1:0] c_q, r_q;
  logic [PW-1:0]    fcol_q, fcur_q, f10, f01, f11, fnext;
  logic             all_pos, all_neg, touch, skip;

  always_comb begin
    f10     = fcur_q + dx_q;
    f01     = fcur_q + dy_q;
    f11     = fcur_q + dxy_q;
    fnext   = fcol_q + dx_q;
    all_pos = !fcur_q[PW-1] && (|fcur_q) && !f10[PW-1] && (|f10)
              && !f01[PW-1] && (|f01) && !f11[PW-1] && (|f11);
    all_neg = fcur_q[PW-1] && f10[PW-1] && f01[PW-1] && f11[PW-1];
    touch   = (sc_q == ec_q) || (sr_q == er_q) || !(all_pos || all_neg);
    skip    = ((c_q == sc_q) && (r_q == sr_q)) || ((c_q == ec_q) && (r_q == er_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      c_q    <= c0;
      r_q    <= r0;
      fcol_q <= f0_q;
      fcur_q <= f0_q;
    end else if (cmd_i.scan_step) begin
      if (r_q == r1) begin
        c_q    <= c_q + CNT_W'(1);
        r_q    <= r0;
        fcol_q <= fnext;
        fcur_q <= fnext;
      end else begin
        r_q    <= r_q + CNT_W'(1);
        fcur_q <= f01;
      end
    end
  end

  always_comb begin
    sts_o.div_done  = div_done;
    sts_o.mul_done  = mul_done;
    sts_o.oor       = |bad_q;
    sts_o.span      = span;
    sts_o.same_cell = (sc_q == ec_q) && (sr_q == er_q);
    sts_o.scan_last = (c_q == c1) && (r_q == r1);
    sts_o.hit       = touch && !skip;
  end

  // one result held back so the last of a run can be marked
  logic [CNT_W-1:0]   n_col, n_row;
  logic               n_oor, n_span;
  logic [2*CNT_W-1:0] n_prod;

  always_comb begin
    n_col  = '0;
    n_row  = '0;
    n_oor  = 1'b0;
    n_span = 1'b0;
    case (cmd_i.src)
      sgcc_pkg::SRC_START: begin
        n_col = sc_q;
        n_row = sr_q;
      end
      sgcc_pkg::SRC_END: begin
        n_col = ec_q;
        n_row = er_q;
      end
      sgcc_pkg::SRC_SCAN: begin
        n_col = c_q;
        n_row = r_q;
      end
      sgcc_pkg::SRC_OOR:  n_oor  = 1'b1;
      sgcc_pkg::SRC_SPAN: n_span = 1'b1;
      default: ;
    endcase
    n_prod = n_row * nx_i + (2*CNT_W)'(n_col);
  end

  logic             pend_v_q, pend_oor_q, pend_span_q;
  logic [IDX_W-1:0] pend_col_q, pend_row_q;
  logic [NUM_W-1:0] pend_num_q;
  logic             out_v_q, out_oor_q, out_span_q, out_last_q;
  logic [IDX_W-1:0] out_col_q, out_row_q;
  logic [NUM_W-1:0] out_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (cmd_i.push) begin
      pend_v_q <= 1'b1;
      out_v_q  <= pend_v_q;
    end else if (cmd_i.flush) begin
      pend_v_q <= 1'b0;
      out_v_q  <= pend_v_q;
    end else begin
      out_v_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.flush) begin
      out_col_q  <= pend_col_q;
      out_row_q  <= pend_row_q;
      out_num_q  <= pend_num_q;
      out_oor_q  <= pend_oor_q;
      out_span_q <= pend_span_q;
      out_last_q <= cmd_i.flush && !cmd_i.push;
    end
    if (cmd_i.push) begin
      pend_col_q  <= n_col[IDX_W-1:0];
      pend_row_q  <= n_row[IDX_W-1:0];
      pend_num_q  <= n_prod[NUM_W-1:0];
      pend_oor_q  <= n_oor;
      pend_span_q <= n_span;
    end
  end

  assign out_valid_o     = out_v_q;
  assign col_index_o     = out_col_q;
  assign row_index_o     = out_row_q;
  assign cell_number_o   = out_num_q;
  assign out_of_range_o  = out_oor_q;
  assign span_too_long_o = out_span_q;
  assign last_cell_o     = out_last_q;

endmodule

FILE: sv/sgcc_ctrl.sv
// controller: sequences divisions, multiplications, checks and the cell scan
module sgcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output sgcc_pkg::cmd_t cmd_o,
  input  sgcc_pkg::sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CHECK,
    S_MUL_GO,
    S_MUL_WAIT,
    S_EMIT_S,
    S_EMIT_E,
    S_SCAN,
    S_FIN
  } state_e;

  state_e     state_q;
  logic [1:0] cnt_q;
  logic       busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_DIV_GO;
            cnt_q   <= '0;
            busy_q  <= 1'b1;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts_i.div_done) begin
            cnt_q   <= cnt_q + 2'd1;
            state_q <= (cnt_q == 2'd3) ? S_CHECK : S_DIV_GO;
          end
        end
        S_CHECK: begin
          cnt_q   <= '0;
          state_q <= (sts_i.oor || sts_i.span) ? S_FIN : S_MUL_GO;
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (sts_i.mul_done) begin
            cnt_q   <= cnt_q + 2'd1;
            state_q <= (cnt_q == 2'd3) ? S_EMIT_S : S_MUL_GO;
          end
        end
        S_EMIT_S: state_q <= sts_i.same_cell ? S_FIN : S_EMIT_E;
        S_EMIT_E: state_q <= S_SCAN;
        S_SCAN: begin
          if (sts_i.scan_last) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.div_sel   = sgcc_pkg::div_sel_e'(cnt_q);
    cmd_o.mul_sel   = sgcc_pkg::mul_sel_e'(cnt_q);
    cmd_o.src       = sgcc_pkg::SRC_SCAN;
    case (state_q)
      S_IDLE:   cmd_o.ld_in  = start_i;
      S_DIV_GO: cmd_o.div_go = 1'b1;
      S_CHECK: begin
        cmd_o.push = sts_i.oor || sts_i.span;
        cmd_o.src  = sts_i.oor ? sgcc_pkg::SRC_OOR : sgcc_pkg::SRC_SPAN;
      end
      S_MUL_GO: cmd_o.mul_go = 1'b1;
      S_EMIT_S: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = sgcc_pkg::SRC_START;
      end
      S_EMIT_E: begin
        cmd_o.push      = 1'b1;
        cmd_o.src       = sgcc_pkg::SRC_END;
        cmd_o.scan_init = 1'b1;
      end
      S_SCAN: begin
        cmd_o.push      = sts_i.hit;
        cmd_o.scan_step = 1'b1;
      end
      S_FIN:    cmd_o.flush = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = busy_q;

endmodule

FILE: bench/segment_grid_cell_cover_tb.sv
// testbench for the segment grid cell cover: scoreboard, stimulus and checking
module segment_grid_cell_cover_tb;

  localparam int LAT_W     = sgcc_pkg::LAT_W;
  localparam int LON_W     = sgcc_pkg::LON_W;
  localparam int CS_W      = sgcc_pkg::CS_W;
  localparam int CNT_W     = sgcc_pkg::CNT_W;
  localparam int IDX_W     = sgcc_pkg::IDX_W;
  localparam int NUM_W     = sgcc_pkg::NUM_W;
  localparam int CFG_W     = sgcc_pkg::CFG_W;
  localparam int CFG_IDX_W = sgcc_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LAT = sgcc_pkg::REG_ORIGIN_LAT;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LON = sgcc_pkg::REG_ORIGIN_LON;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = sgcc_pkg::REG_CELL_SIZE;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = sgcc_pkg::REG_CELLS_X;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = sgcc_pkg::REG_CELLS_Y;

  localparam logic [CS_W-1:0]  CELL_SIZE_RST = sgcc_pkg::CELL_SIZE_RST;
  localparam logic [CNT_W-1:0] CELLS_RST     = sgcc_pkg::CELLS_RST;

  localparam int    MAX_SIDE = 1024;
  localparam int    SPAN_MAX = 8;
  localparam longint LIMIT   = 1000000;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [NUM_W-1:0] num;
    logic             oor;
    logic             span;
    logic             last;
  } cell_res_t;

  typedef struct packed {
    logic [LAT_W-1:0] lat0;
    logic [LON_W-1:0] lon0;
    logic [LAT_W-1:0] lat1;
    logic [LON_W-1:0] lon1;
  } seg_t;

  class cover_scoreboard;
    logic signed [LAT_W-1:0] org_lat;
    logic signed [LON_W-1:0] org_lon;
    logic [CS_W-1:0]         csize;
    logic [CNT_W-1:0]        ncols;
    logic [CNT_W-1:0]        nrows;
    cell_res_t               cells_due[$];
    int                      errors;

    function new();
      org_lat = '0;
      org_lon = '0;
      csize   = CELL_SIZE_RST;
      ncols   = CELLS_RST;
      nrows   = CELLS_RST;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ORIGIN_LAT: org_lat = data[LAT_W-1:0];
        REG_ORIGIN_LON: org_lon = data[LON_W-1:0];
        REG_CELL_SIZE:  csize   = data[CS_W-1:0];
        REG_CELLS_X:    ncols   = data[CNT_W-1:0];
        REG_CELLS_Y:    nrows   = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint floor_cell(longint d, longint cs, longint n);
      longint q;
      if (cs <= 0) return -1;
      q = d / cs;
      if (d % cs != 0 && d < 0) q--;
      return (q < 0 || q >= n) ? -1 : q;
    endfunction

    function int cross_sgn(longint a, longint b, longint c, longint d);
      wide_t wa, wb, wc, wd, diff;
      wa = a;
      wb = b;
      wc = c;
      wd = d;
      diff = wa * wb - wc * wd;
      return diff < 0 ? -1 : (diff == 0 ? 0 : 1);
    endfunction

    function cell_res_t mk(longint c, longint r, longint nx);
      cell_res_t x;
      longint n;
      n = r * nx + c;
      x = '0;
      x.col = c[IDX_W-1:0];
      x.row = r[IDX_W-1:0];
      x.num = n[NUM_W-1:0];
      return x;
    endfunction

    function void note(seg_t s);
      longint nx, ny, cs, py, px, qy, qx, sr, sc, er, ec, c0, c1, r0, r1, ux, uy, cx, cy;
      int pos, neg, sg;
      cell_res_t run[$];
      cell_res_t x;
      cs = csize;
      nx = ncols > MAX_SIDE ? MAX_SIDE : ncols;
      ny = nrows > MAX_SIDE ? MAX_SIDE : nrows;
      py = longint'(signed'(s.lat0)) - longint'(org_lat);
      px = longint'(signed'(s.lon0)) - longint'(org_lon);
      qy = longint'(signed'(s.lat1)) - longint'(org_lat);
      qx = longint'(signed'(s.lon1)) - longint'(org_lon);
      sr = floor_cell(py, cs, ny);
      sc = floor_cell(px, cs, nx);
      er = floor_cell(qy, cs, ny);
      ec = floor_cell(qx, cs, nx);
      if (sr < 0 || sc < 0 || er < 0 || ec < 0) begin
        x = '0;
        x.oor = 1'b1;
        x.last = 1'b1;
        cells_due = {cells_due, x};
        return;
      end
      c0 = sc < ec ? sc : ec;
      c1 = sc < ec ? ec : sc;
      r0 = sr < er ? sr : er;
      r1 = sr < er ? er : sr;
      if (c1 - c0 + 1 > SPAN_MAX || r1 - r0 + 1 > SPAN_MAX) begin
        x = '0;
        x.span = 1'b1;
        x.last = 1'b1;
        cells_due = {cells_due, x};
        return;
      end
      run = {run, mk(sc, sr, nx)};
      if (sc != ec || sr != er) begin
        run = {run, mk(ec, er, nx)};
        if (sc == ec) begin
          for (longint r = r0 + 1; r < r1; r++) run = {run, mk(sc, r, nx)};
        end else if (sr == er) begin
          for (longint c = c0 + 1; c < c1; c++) run = {run, mk(c, sr, nx)};
        end else begin
          ux = qx - px;
          uy = qy - py;
          for (longint c = c0; c <= c1; c++) begin
            for (longint r = r0; r <= r1; r++) begin
              if ((c == sc && r == sr) || (c == ec && r == er)) continue;
              pos = 0;
              neg = 0;
              for (int i = 0; i < 4; i++) begin
                cx = (c + (i & 1)) * cs - px;
                cy = (r + (i >> 1)) * cs - py;
                sg = cross_sgn(ux, cy, uy, cx);
                if (sg > 0) pos++;
                else if (sg < 0) neg++;
              end
              if (pos != 4 && neg != 4 && run.size() < SPAN_MAX * SPAN_MAX)
                run = {run, mk(c, r, nx)};
            end
          end
        end
      end
      run[run.size() - 1].last = 1'b1;
      cells_due = {cells_due, run};
    endfunction

    function void check(cell_res_t got);
      cell_res_t want;
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell transaction %p", $time, got);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      if (got.col !== want.col) begin
        $display("%0t: col_index expected %0d actual %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: row_index expected %0d actual %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.num !== want.num) begin
        $display("%0t: cell_number expected %0d actual %0d", $time, want.num, got.num);
        errors++;
      end
      if (got.oor !== want.oor) begin
        $display("%0t: out_of_range expected %0b actual %0b", $time, want.oor, got.oor);
        errors++;
      end
      if (got.span !== want.span) begin
        $display("%0t: span_too_long expected %0b actual %0b", $time, want.span, got.span);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_cell expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [LAT_W-1:0] start_lat_i;
  logic [LON_W-1:0] start_lon_i;
  logic [LAT_W-1:0] end_lat_i;
  logic [LON_W-1:0] end_lon_i;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             out_valid_o;
  logic [IDX_W-1:0] col_index_o;
  logic [IDX_W-1:0] row_index_o;
  logic [NUM_W-1:0] cell_number_o;
  logic             out_of_range_o;
  logic             span_too_long_o;
  logic             last_cell_o;

  cover_scoreboard sb = new();
  longint cycles = 0;
  longint g_olat, g_olon, g_cs, g_nx, g_ny;

  segment_grid_cell_cover dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note('{start_lat_i, start_lon_i, end_lat_i, end_lon_i});
    if (rst_ni && out_valid_o)
      sb.check('{col_index_o, row_index_o, cell_number_o, out_of_range_o,
                 span_too_long_o, last_cell_o});
  end

  task automatic wait_idle();
    @(posedge clk_i);
    while (sb.cells_due.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_grid(longint olat, longint olon, longint cs, longint nx, longint ny);
    logic [CFG_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0] idxs[5];
    wait_idle();
    vals = '{olat[CFG_W-1:0], olon[CFG_W-1:0], cs[CFG_W-1:0], nx[CFG_W-1:0], ny[CFG_W-1:0]};
    idxs = '{REG_ORIGIN_LAT, REG_ORIGIN_LON, REG_CELL_SIZE, REG_CELLS_X, REG_CELLS_Y};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      sb.set_reg(idxs[i], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    g_olat = olat;
    g_olon = olon;
    g_cs   = cs;
    g_nx   = nx > MAX_SIDE ? MAX_SIDE : nx;
    g_ny   = ny > MAX_SIDE ? MAX_SIDE : ny;
  endtask

  // leaves start high; the caller lowers it at the end of a burst
  task automatic push_seg(seg_t s);
    start_i     <= 1'b1;
    start_lat_i <= s.lat0;
    start_lon_i <= s.lon0;
    end_lat_i   <= s.lat1;
    end_lon_i   <= s.lon1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_gap(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic longint pick_frac();
    int k;
    if (g_cs <= 0) return 0;
    k = $urandom_range(0, 3);
    if (k == 0) return 0;
    if (k == 1) return g_cs - 1;
    return longint'($urandom) % g_cs;
  endfunction

  function automatic seg_t cells_seg(longint sc, longint sr, longint fs0, longint fs1,
                                     longint ec, longint er, longint fe0, longint fe1);
    longint a, b, c, d;
    a = g_olat + sr * g_cs + fs0;
    b = g_olon + sc * g_cs + fs1;
    c = g_olat + er * g_cs + fe0;
    d = g_olon + ec * g_cs + fe1;
    return '{a[LAT_W-1:0], b[LON_W-1:0], c[LAT_W-1:0], d[LON_W-1:0]};
  endfunction

  function automatic longint near(longint base, longint n, int reach);
    longint v;
    v = base + $signed($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v >= n) v = n - 1;
    return v;
  endfunction

  function automatic seg_t random_seg();
    int mode;
    longint nx, ny, sc, sr, ec, er;
    logic [127:0] rnd;
    seg_t s;
    nx = g_nx < 1 ? 1 : g_nx;
    ny = g_ny < 1 ? 1 : g_ny;
    mode = $urandom_range(0, 19);
    sc = $urandom_range(0, nx - 1);
    sr = $urandom_range(0, ny - 1);
    ec = near(sc, nx, SPAN_MAX - 1);
    er = near(sr, ny, SPAN_MAX - 1);
    if (mode < 2) begin
      rnd = {$urandom, $urandom, $urandom, $urandom};
      s = rnd[$bits(seg_t)-1:0];
      return s;
    end
    if (mode == 2) ec = $urandom_range(0, 1) ? -1 : nx;
    if (mode == 3) er = $urandom_range(0, 1) ? -1 : ny;
    if (mode == 4) ec = sc + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(8, 12);
    if (mode == 5) er = sr + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(8, 12);
    if (mode == 6) ec = sc;
    if (mode == 7) er = sr;
    return cells_seg(sc, sr, pick_frac(), pick_frac(), ec, er, pick_frac(), pick_frac());
  endfunction

  task automatic run_random(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && left > 0; i++) begin
        push_seg(random_seg());
        left--;
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15));
    end
  endtask

  task automatic run_directed();
    seg_t s;
    push_seg(cells_seg(5, 5, 7, 9, 5, 5, 100, 3));
    push_seg(cells_seg(3, 2, 0, 0, 3, 9, g_cs - 1, g_cs - 1));
    push_seg(cells_seg(3, 9, 11, 5, 3, 2, 3, 8));
    push_seg(cells_seg(100, 4, 1, 2, 107, 4, 9, 9));
    push_seg(cells_seg(107, 4, 5, 5, 100, 4, 0, 0));
    idle_gap(3);
    push_seg(cells_seg(0, 0, 0, 0, 7, 7, 0, 0));
    push_seg(cells_seg(7, 0, 0, 0, 0, 7, 0, 0));
    push_seg(cells_seg(20, 30, 1, 2, 27, 37, g_cs - 2, g_cs - 7));
    push_seg(cells_seg(20, 30, 0, 0, 21, 31, 0, 0));
    push_seg(cells_seg(0, 0, 5, 5, 0, 8, 5, 5));
    push_seg(cells_seg(0, 0, 5, 5, 8, 0, 5, 5));
    push_seg(cells_seg(0, 0, 0, 0, g_nx - 1, g_ny - 1, g_cs - 1, g_cs - 1));
    push_seg(cells_seg(g_nx - 1, g_ny - 1, g_cs - 1, g_cs - 1, g_nx - 1, g_ny - 1, 0, 0));
    push_seg(cells_seg(-1, 0, 0, 0, 0, 0, 0, 0));
    push_seg(cells_seg(0, g_ny, 0, 0, 0, 0, 0, 0));
    s = '{30'd377487360, 31'd754974720, 30'h20000000 + 30'd0, 31'h40000000};
    push_seg(s);
    s = '{{LAT_W{1'b1}}, {LON_W{1'b1}}, {LAT_W{1'b0}}, {LON_W{1'b0}}};
    push_seg(s);
    idle_gap(2);
  endtask

  initial begin
    start_i     = 1'b0;
    start_lat_i = '0;
    start_lon_i = '0;
    end_lat_i   = '0;
    end_lon_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_ORIGIN_LAT;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    g_olat = 0;
    g_olon = 0;
    g_cs   = CELL_SIZE_RST;
    g_nx   = 1;
    g_ny   = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_random(20);
    set_grid(-377487360, -754974720, 4194304, 360, 180);
    run_directed();
    run_random(100);
    set_grid(-1000, 2000, 1, 1024, 1024);
    run_random(60);
    set_grid(-90000, -123456, 37, 2047, 1500);
    run_random(40);
    set_grid(12345, -54321, 0, 16, 16);
    run_random(15);
    set_grid(-377487360, -754974720, 1073741824, 1, 1);
    run_random(15);
    set_grid(0, 0, 3, 5, 7);
    run_random(80);
    set_grid(377487360, 754974720, 1, 0, 1024);
    run_random(10);
    set_grid(377487360, 754974720, 1, 1024, 1024);
    run_random(10);
    idle_gap(0);

    wait_idle();
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.cells_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.cells_due.size() != 0)
        $display("%0t: %0d cell transactions never arrived", $time, sb.cells_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
